[design/sd_spi_host_engine_defines.svh]
// Assertion macros used by the checker of the SPI host engine.
`ifndef SD_SPI_HOST_ENGINE_DEFINES_SVH
`define SD_SPI_HOST_ENGINE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define SSHE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property that holds in the cycle after its trigger.
`define SSHE_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

[design/sshe_pkg.sv]
package sshe_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int BIDX_W = 12;

	// Request classes decoded from the action field
	typedef enum logic [1:0] {
		REQ_INIT  = 2'd0,
		REQ_READ  = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_XCHG  = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		PH_IDLE, PH_WAKE, PH_FRAME, PH_RESP, PH_TAIL, PH_RELEASE,
		PH_RD_TOKEN, PH_RD_DATA, PH_RD_CRC,
		PH_WR_TOKEN, PH_WR_DATA, PH_WR_CRC, PH_WR_RESP, PH_WR_BUSY
	} phase_t;

	// Command indexes
	localparam logic [5:0] CMD0  = 6'd0;
	localparam logic [5:0] CMD1  = 6'd1;
	localparam logic [5:0] CMD8  = 6'd8;
	localparam logic [5:0] CMD16 = 6'd16;
	localparam logic [5:0] CMD17 = 6'd17;
	localparam logic [5:0] CMD24 = 6'd24;
	localparam logic [5:0] ACMD41 = 6'd41;
	localparam logic [5:0] CMD55 = 6'd55;
	localparam logic [5:0] CMD58 = 6'd58;

	// Completion status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_NO_IDLE     = 4'd1;
	localparam logic [3:0] ST_VOLTAGE     = 4'd2;
	localparam logic [3:0] ST_APPCMD      = 4'd3;
	localparam logic [3:0] ST_INIT_TMO    = 4'd4;
	localparam logic [3:0] ST_BLOCKLEN    = 4'd5;
	localparam logic [3:0] ST_CMD_REJ     = 4'd6;
	localparam logic [3:0] ST_BAD_TOKEN   = 4'd7;
	localparam logic [3:0] ST_WR_REJ      = 4'd8;
	localparam logic [3:0] ST_BUSY_TMO    = 4'd9;

	// Card kinds
	localparam logic [1:0] CARD_V1   = 2'd0;
	localparam logic [1:0] CARD_SD   = 2'd1;
	localparam logic [1:0] CARD_SDHC = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] REG_RESP_POLL  = 2'd0;
	localparam logic [1:0] REG_INIT_RETRY = 2'd1;
	localparam logic [1:0] REG_BUSY_POLL  = 2'd2;
	localparam logic [1:0] REG_WAKE       = 2'd3;

	typedef struct packed {
		req_t        req;
		logic [31:0] blk_num;
		logic [7:0]  rx_byte;
		logic [7:0]  write_byte;
	} item_t;

	typedef struct packed {
		logic [15:0] resp_poll_limit;
		logic [15:0] init_retry_limit;
		logic [15:0] busy_poll_limit;
		logic [7:0]  wake_bytes;
	} cfg_t;

	typedef struct packed {
		logic [7:0] tx_byte;
		logic       tx_start;
		logic       select_card;
		logic       slow_clock;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       write_byte_taken;
		logic       done_res;
		logic [3:0] status;
		logic [1:0] card_type;
	} res_t;

	// Byte idx of the six-byte command frame
	function automatic logic [7:0] frame_byte(logic [5:0] cmd, logic [2:0] idx,
		logic [31:0] tgt);
		logic [31:0] arg;
		logic [7:0]  b;
		priority if (cmd == CMD8) arg = 32'h0000_01AA;
		else if (cmd == ACMD41) arg = 32'h4000_0000;
		else if (cmd == CMD16) arg = 32'(BLOCK_BYTES);
		else if (cmd == CMD17 || cmd == CMD24) arg = tgt;
		else arg = 32'd0;
		unique case (idx)
			3'd0: b = {2'b01, cmd};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: b = (cmd == CMD8) ? 8'h87 : 8'h95;
		endcase
		return b;
	endfunction

endpackage

[design/sshe_in_if.sv]
interface sshe_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [31:0] blk_num;
	logic [7:0]  rx_byte;
	logic [7:0]  write_byte;

	modport source (output valid, action, blk_num, rx_byte, write_byte, input ready);
	modport sink (input valid, action, blk_num, rx_byte, write_byte, output ready);
endinterface

[design/sshe_out_if.sv]
interface sshe_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       tx_start;
	logic       select_card;
	logic       slow_clock;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       write_byte_taken;
	logic       done_res;
	logic [3:0] status;
	logic [1:0] card_type;

	modport source (output valid, tx_byte, tx_start, select_card, slow_clock, read_byte,
		read_valid, write_byte_taken, done_res, status, card_type, input ready);
	modport sink (input valid, tx_byte, tx_start, select_card, slow_clock, read_byte,
		read_valid, write_byte_taken, done_res, status, card_type, output ready);
endinterface

[design/sshe_front.sv]
module sshe_front (
	input  logic            clk,
	input  logic            arst_n,
	sshe_in_if.sink         in_ch,
	output logic            q_valid,
	output sshe_pkg::item_t q_item,
	input  logic            q_pop
);

	sshe_pkg::item_t buf_q [2];
	logic [1:0] cnt_q;
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic       push;
	sshe_pkg::item_t cls;

	// Classify the incoming word
	always_comb begin
		cls.req        = sshe_pkg::req_t'(in_ch.action);
		cls.blk_num    = in_ch.blk_num;
		cls.rx_byte    = in_ch.rx_byte;
		cls.write_byte = in_ch.write_byte;
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push        = in_ch.valid && in_ch.ready;
	assign q_valid     = (cnt_q != 2'd0);
	assign q_item      = buf_q[rd_ptr_q];

	// Store accepted words
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= cls;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (q_pop) rd_ptr_q <= ~rd_ptr_q;
			unique case ({push, q_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[design/sshe_back.sv]
module sshe_back (
	input  logic            clk,
	input  logic            arst_n,
	input  sshe_pkg::cfg_t  cfg,
	input  logic            q_valid,
	input  sshe_pkg::item_t q_item,
	output logic            q_pop,
	sshe_out_if.source      out_ch
);

	sshe_pkg::phase_t phase_q, phase_n;
	logic [1:0]  kind_q, kind_n;
	logic [15:0] poll_q, poll_n;
	logic [15:0] retry_q, retry_n;
	logic [sshe_pkg::BIDX_W-1:0] bidx_q, bidx_n;
	logic [2:0]  fidx_q, fidx_n;
	logic [31:0] resp_q, resp_n;
	logic [31:0] tgt_q, tgt_n;
	logic        slow_q, slow_n;
	logic [5:0]  cmd_q, cmd_n;
	logic [5:0]  next_cmd_q, next_cmd_n;
	logic        rel_ends_q, rel_ends_n;
	logic [3:0]  end_st_q, end_st_n;
	logic        out_valid_q;
	sshe_pkg::res_t res_q, res;

	logic        fire;
	logic [16:0] poll_inc;
	logic [16:0] retry_inc;
	logic [sshe_pkg::BIDX_W:0] bidx_inc;
	logic [2:0]  fidx_inc;
	logic        rsp_hit;
	logic [7:0]  rsp_r;
	logic [31:0] word_n;
	logic [7:0]  rx;

	assign fire      = q_valid && (!out_valid_q || out_ch.ready);
	assign q_pop     = fire;
	assign rx        = q_item.rx_byte;
	assign poll_inc  = {1'b0, poll_q} + 17'd1;
	assign retry_inc = {1'b0, retry_q} + 17'd1;
	assign bidx_inc  = {1'b0, bidx_q} + 1'b1;
	assign fidx_inc  = fidx_q + 3'd1;
	assign word_n    = {resp_q[23:0], rx};

	// Resolve a response poll: hit on a non-idle byte or on timeout
	always_comb begin
		rsp_hit = 1'b1;
		rsp_r   = rx;
		if (rx == 8'hFF) begin
			rsp_r = 8'hFF;
			rsp_hit = (poll_inc >= {1'b0, cfg.resp_poll_limit});
		end
	end

	// Next state and result word
	always_comb begin
		phase_n    = phase_q;
		kind_n     = kind_q;
		poll_n     = poll_q;
		retry_n    = retry_q;
		bidx_n     = bidx_q;
		fidx_n     = fidx_q;
		resp_n     = resp_q;
		tgt_n      = tgt_q;
		slow_n     = slow_q;
		cmd_n      = cmd_q;
		next_cmd_n = next_cmd_q;
		rel_ends_n = rel_ends_q;
		end_st_n   = end_st_q;
		res        = '0;
		res.tx_byte = 8'hFF;
		res.select_card = !(phase_q == sshe_pkg::PH_IDLE || phase_q == sshe_pkg::PH_WAKE
			|| phase_q == sshe_pkg::PH_RELEASE);

		if (q_item.req == sshe_pkg::REQ_XCHG) begin
			unique case (phase_q)
				sshe_pkg::PH_IDLE: ;
				sshe_pkg::PH_WAKE: begin
					bidx_n = bidx_inc[sshe_pkg::BIDX_W-1:0];
					if (bidx_inc < {{(sshe_pkg::BIDX_W-7){1'b0}}, cfg.wake_bytes}) begin
						res.tx_start = 1'b1; res.select_card = 1'b0;
					end else begin
						cmd_n = sshe_pkg::CMD0; fidx_n = 3'd0; phase_n = sshe_pkg::PH_FRAME;
						res.tx_byte = sshe_pkg::frame_byte(sshe_pkg::CMD0, 3'd0, tgt_q);
						res.tx_start = 1'b1; res.select_card = 1'b1;
					end
				end
				sshe_pkg::PH_FRAME: begin
					fidx_n = fidx_inc;
					res.tx_start = 1'b1; res.select_card = 1'b1;
					if (fidx_inc < 3'd6) begin
						res.tx_byte = sshe_pkg::frame_byte(cmd_q, fidx_inc, tgt_q);
					end else begin
						phase_n = sshe_pkg::PH_RESP; poll_n = 16'd0;
					end
				end
				sshe_pkg::PH_RESP: begin
					if (rx == 8'hFF) poll_n = poll_inc[15:0];
					res.tx_start = 1'b1; res.select_card = 1'b1;
					if (rsp_hit) begin
						// Default: release, then a command or an end
						phase_n = sshe_pkg::PH_RELEASE;
						res.select_card = 1'b0;
						unique case (cmd_q)
							sshe_pkg::CMD0: begin
								if (rsp_r != 8'h01) begin
									rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_NO_IDLE;
								end else begin
									rel_ends_n = 1'b0; next_cmd_n = sshe_pkg::CMD8;
								end
							end
							sshe_pkg::CMD8: begin
								if (rsp_r == 8'h01) begin
									phase_n = sshe_pkg::PH_TAIL; fidx_n = 3'd0; resp_n = '0;
									res.select_card = 1'b1;
								end else if (rsp_r == 8'h05) begin
									kind_n = sshe_pkg::CARD_V1; retry_n = '0;
									cmd_n = sshe_pkg::CMD1; fidx_n = 3'd0;
									phase_n = sshe_pkg::PH_FRAME; res.select_card = 1'b1;
									res.tx_byte = sshe_pkg::frame_byte(sshe_pkg::CMD1, 3'd0,
										tgt_q);
								end else begin
									rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_VOLTAGE;
								end
							end
							sshe_pkg::CMD55: begin
								if (rsp_r != 8'h01) begin
									rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_APPCMD;
								end else begin
									rel_ends_n = 1'b0; next_cmd_n = sshe_pkg::ACMD41;
								end
							end
							sshe_pkg::ACMD41, sshe_pkg::CMD1: begin
								if (rsp_r == 8'h00) begin
									rel_ends_n = 1'b0; next_cmd_n = sshe_pkg::CMD58;
								end else begin
									retry_n = retry_inc[15:0];
									if (retry_inc >= {1'b0, cfg.init_retry_limit}) begin
										rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_INIT_TMO;
									end else begin
										rel_ends_n = 1'b0;
										next_cmd_n = (kind_q == sshe_pkg::CARD_SD) ?
											sshe_pkg::CMD55 : sshe_pkg::CMD1;
									end
								end
							end
							sshe_pkg::CMD58: begin
								res.select_card = 1'b1;
								if (rsp_r == 8'h00) begin
									phase_n = sshe_pkg::PH_TAIL; fidx_n = 3'd0; resp_n = '0;
								end else begin
									cmd_n = sshe_pkg::CMD16; fidx_n = 3'd0;
									phase_n = sshe_pkg::PH_FRAME;
									res.tx_byte = sshe_pkg::frame_byte(sshe_pkg::CMD16, 3'd0,
										tgt_q);
								end
							end
							sshe_pkg::CMD16: begin
								rel_ends_n = 1'b1;
								end_st_n = (rsp_r != 8'h00) ? sshe_pkg::ST_BLOCKLEN :
									sshe_pkg::ST_OK;
							end
							sshe_pkg::CMD17: begin
								if (rsp_r != 8'h00) begin
									rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_CMD_REJ;
								end else begin
									phase_n = sshe_pkg::PH_RD_TOKEN; poll_n = '0;
									res.select_card = 1'b1;
								end
							end
							default: begin
								if (rsp_r != 8'h00) begin
									rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_CMD_REJ;
								end else begin
									phase_n = sshe_pkg::PH_WR_TOKEN;
									res.tx_byte = 8'hFE; res.select_card = 1'b1;
								end
							end
						endcase
					end
				end
				sshe_pkg::PH_TAIL: begin
					resp_n = word_n;
					fidx_n = fidx_inc;
					res.tx_start = 1'b1;
					if (fidx_inc < 3'd4) begin
						res.select_card = 1'b1;
					end else begin
						phase_n = sshe_pkg::PH_RELEASE; res.select_card = 1'b0;
						if (cmd_q == sshe_pkg::CMD8) begin
							if (word_n == 32'h0000_01AA) begin
								kind_n = sshe_pkg::CARD_SD; retry_n = '0;
								rel_ends_n = 1'b0; next_cmd_n = sshe_pkg::CMD55;
							end else begin
								rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_VOLTAGE;
							end
						end else begin
							if (word_n[30]) kind_n = sshe_pkg::CARD_SDHC;
							rel_ends_n = 1'b0; next_cmd_n = sshe_pkg::CMD16;
						end
					end
				end
				sshe_pkg::PH_RELEASE: begin
					if (rel_ends_q) begin
						if (cmd_q == sshe_pkg::CMD16 && end_st_q == sshe_pkg::ST_OK)
							slow_n = 1'b0;
						phase_n = sshe_pkg::PH_IDLE;
						res.done_res = 1'b1; res.status = end_st_q; res.select_card = 1'b0;
					end else begin
						cmd_n = next_cmd_q; fidx_n = 3'd0; phase_n = sshe_pkg::PH_FRAME;
						res.tx_byte = sshe_pkg::frame_byte(next_cmd_q, 3'd0, tgt_q);
						res.tx_start = 1'b1; res.select_card = 1'b1;
					end
				end
				sshe_pkg::PH_RD_TOKEN: begin
					if (rx == 8'hFF) poll_n = poll_inc[15:0];
					res.tx_start = 1'b1; res.select_card = 1'b1;
					if (rsp_hit) begin
						if (rsp_r != 8'hFE) begin
							phase_n = sshe_pkg::PH_RELEASE; res.select_card = 1'b0;
							rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_BAD_TOKEN;
						end else begin
							phase_n = sshe_pkg::PH_RD_DATA; bidx_n = '0;
						end
					end
				end
				sshe_pkg::PH_RD_DATA: begin
					res.read_byte = rx; res.read_valid = 1'b1;
					bidx_n = bidx_inc[sshe_pkg::BIDX_W-1:0];
					res.tx_start = 1'b1; res.select_card = 1'b1;
					if (bidx_inc >= (sshe_pkg::BIDX_W+1)'(sshe_pkg::BLOCK_BYTES)) begin
						phase_n = sshe_pkg::PH_RD_CRC; fidx_n = 3'd0;
					end
				end
				sshe_pkg::PH_RD_CRC: begin
					fidx_n = fidx_inc;
					res.tx_start = 1'b1; res.select_card = 1'b1;
					if (fidx_inc >= 3'd2) begin
						phase_n = sshe_pkg::PH_RELEASE; res.select_card = 1'b0;
						rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_OK;
					end
				end
				sshe_pkg::PH_WR_TOKEN: begin
					phase_n = sshe_pkg::PH_WR_DATA; bidx_n = '0;
					res.tx_byte = q_item.write_byte; res.tx_start = 1'b1;
					res.select_card = 1'b1; res.write_byte_taken = 1'b1;
				end
				sshe_pkg::PH_WR_DATA: begin
					bidx_n = bidx_inc[sshe_pkg::BIDX_W-1:0];
					res.tx_start = 1'b1; res.select_card = 1'b1;
					if (bidx_inc < (sshe_pkg::BIDX_W+1)'(sshe_pkg::BLOCK_BYTES)) begin
						res.tx_byte = q_item.write_byte; res.write_byte_taken = 1'b1;
					end else begin
						phase_n = sshe_pkg::PH_WR_CRC; fidx_n = 3'd0;
					end
				end
				sshe_pkg::PH_WR_CRC: begin
					fidx_n = fidx_inc;
					res.tx_start = 1'b1; res.select_card = 1'b1;
					if (fidx_inc >= 3'd2) phase_n = sshe_pkg::PH_WR_RESP;
				end
				sshe_pkg::PH_WR_RESP: begin
					res.tx_start = 1'b1;
					if (rx[3:0] != 4'h5) begin
						phase_n = sshe_pkg::PH_RELEASE; res.select_card = 1'b0;
						rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_WR_REJ;
					end else begin
						phase_n = sshe_pkg::PH_WR_BUSY; poll_n = '0; res.select_card = 1'b1;
					end
				end
				sshe_pkg::PH_WR_BUSY: begin
					res.tx_start = 1'b1; res.select_card = 1'b1;
					if (rx != 8'h00) begin
						phase_n = sshe_pkg::PH_RELEASE; res.select_card = 1'b0;
						rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_OK;
					end else begin
						poll_n = poll_inc[15:0];
						if (poll_inc >= {1'b0, cfg.busy_poll_limit}) begin
							phase_n = sshe_pkg::PH_RELEASE; res.select_card = 1'b0;
							rel_ends_n = 1'b1; end_st_n = sshe_pkg::ST_BUSY_TMO;
						end
					end
				end
				default: ;
			endcase
		end else if (phase_q == sshe_pkg::PH_IDLE) begin
			res.tx_start = 1'b1;
			if (q_item.req == sshe_pkg::REQ_INIT) begin
				slow_n = 1'b1; bidx_n = '0; phase_n = sshe_pkg::PH_WAKE;
				res.select_card = 1'b0;
			end else begin
				tgt_n = (kind_q == sshe_pkg::CARD_SDHC) ? q_item.blk_num :
					32'(q_item.blk_num * 32'(sshe_pkg::BLOCK_BYTES));
				cmd_n = (q_item.req == sshe_pkg::REQ_READ) ? sshe_pkg::CMD17 :
					sshe_pkg::CMD24;
				fidx_n = 3'd0; phase_n = sshe_pkg::PH_FRAME;
				res.tx_byte = sshe_pkg::frame_byte(cmd_n, 3'd0, tgt_q);
				res.select_card = 1'b1;
			end
		end
		res.slow_clock = slow_n;
		res.card_type  = kind_n;
	end

	// Hold engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= sshe_pkg::PH_IDLE;
			kind_q     <= sshe_pkg::CARD_V1;
			poll_q     <= '0;
			retry_q    <= '0;
			bidx_q     <= '0;
			fidx_q     <= '0;
			resp_q     <= '0;
			tgt_q      <= '0;
			slow_q     <= 1'b1;
			cmd_q      <= sshe_pkg::CMD0;
			next_cmd_q <= sshe_pkg::CMD0;
			rel_ends_q <= 1'b0;
			end_st_q   <= sshe_pkg::ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q    <= phase_n;
				kind_q     <= kind_n;
				poll_q     <= poll_n;
				retry_q    <= retry_n;
				bidx_q     <= bidx_n;
				fidx_q     <= fidx_n;
				resp_q     <= resp_n;
				tgt_q      <= tgt_n;
				slow_q     <= slow_n;
				cmd_q      <= cmd_n;
				next_cmd_q <= next_cmd_n;
				rel_ends_q <= rel_ends_n;
				end_st_q   <= end_st_n;
			end
			if (fire) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (fire) res_q <= res;
	end

	assign out_ch.valid            = out_valid_q;
	assign out_ch.tx_byte          = res_q.tx_byte;
	assign out_ch.tx_start         = res_q.tx_start;
	assign out_ch.select_card      = res_q.select_card;
	assign out_ch.slow_clock       = res_q.slow_clock;
	assign out_ch.read_byte        = res_q.read_byte;
	assign out_ch.read_valid       = res_q.read_valid;
	assign out_ch.write_byte_taken = res_q.write_byte_taken;
	assign out_ch.done_res         = res_q.done_res;
	assign out_ch.status           = res_q.status;
	assign out_ch.card_type        = res_q.card_type;

endmodule

[design/sd_spi_host_engine.sv]
// SD card SPI-mode host engine. Each input word is a start request (init, block read,
// block write) or a finished byte exchange; each yields one result word with the next byte
// to shift, chip select, clock speed, read data, write handshake and completion status.
// Words enter a two-deep queue and a state update consumes one word per clock whenever the
// output register is free, so the sustained rate is one word per cycle. The user must set
// limits over the APB port only while the engine idles; the block does not enforce it.
module sd_spi_host_engine (
	input  logic        clk,
	input  logic        arst_n,
	sshe_in_if.sink     in_ch,
	sshe_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sshe_pkg::cfg_t  cfg_q;
	sshe_pkg::item_t q_item;
	logic            q_valid;
	logic            q_pop;
	logic            wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.resp_poll_limit  <= 16'd4095;
			cfg_q.init_retry_limit <= 16'd4095;
			cfg_q.busy_poll_limit  <= 16'hFFFF;
			cfg_q.wake_bytes       <= 8'd10;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				sshe_pkg::REG_RESP_POLL:  cfg_q.resp_poll_limit  <= pwdata[15:0];
				sshe_pkg::REG_INIT_RETRY: cfg_q.init_retry_limit <= pwdata[15:0];
				sshe_pkg::REG_BUSY_POLL:  cfg_q.busy_poll_limit  <= pwdata[15:0];
				default:                  cfg_q.wake_bytes       <= pwdata[7:0];
			endcase
		end
	end

	// Read back configuration
	always_comb begin
		unique case (paddr[3:2])
			sshe_pkg::REG_RESP_POLL:  prdata = {16'd0, cfg_q.resp_poll_limit};
			sshe_pkg::REG_INIT_RETRY: prdata = {16'd0, cfg_q.init_retry_limit};
			sshe_pkg::REG_BUSY_POLL:  prdata = {16'd0, cfg_q.busy_poll_limit};
			default:                  prdata = {24'd0, cfg_q.wake_bytes};
		endcase
	end

	sshe_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	sshe_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.out_ch  (out_ch)
	);

endmodule

[design/sshe_checker.sv]
`include "sd_spi_host_engine_defines.svh"

module sshe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic       tx_start,
	input logic [7:0] tx_byte,
	input logic       select_card,
	input logic       read_valid,
	input logic       done_res,
	input logic [3:0] status
);

	`SSHE_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result word dropped")
	`SSHE_ASSERT(a_idle_ff, out_valid && !tx_start |-> tx_byte == 8'hFF, "idle byte not FF")
	`SSHE_ASSERT(a_status, out_valid && !done_res |-> status == 4'd0, "status without done")
	`SSHE_ASSERT(a_rd_sel, out_valid && read_valid |-> tx_start && select_card, "read off bus")
	`SSHE_ASSERT(a_done, out_valid && done_res |-> !select_card && !tx_start, "done selected")

endmodule

bind sd_spi_host_engine sshe_checker u_sshe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_ch.valid),
	.out_ready   (out_ch.ready),
	.tx_start    (out_ch.tx_start),
	.tx_byte     (out_ch.tx_byte),
	.select_card (out_ch.select_card),
	.read_valid  (out_ch.read_valid),
	.done_res    (out_ch.done_res),
	.status      (out_ch.status)
);
